>>> design/assert_macros.svh
// Assertion macros for the compensator RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PTC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTC_ASSERT(label, clk, rstn, prop, msg)
`define PTC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> design/ptc_pkg.sv
// Package for the pressure/temperature compensator: types and constants.
// No dependencies.
package ptc_pkg;
  localparam int unsigned RawW = 20;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned AddrW = 5;
  localparam int unsigned FrontStages = 9;

  typedef enum logic [1:0] {
    RegTemp = 2'd0,
    RegPressA = 2'd1,
    RegPressB = 2'd2,
    RegPressC = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {StIdle, StDiv, StPost, StOut} back_state_e;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [15:0] pc;
  } calib_t;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_invalid;
  } out_item_t;

  // Division job handed from the front to the back.
  typedef struct packed {
    logic [31:0] temp;
    logic [63:0] num;
    logic [63:0] den;
  } job_t;
endpackage

>>> design/ptc_stream_if.sv
// Valid/ready stream interface with a generic payload.
// Depends on nothing but the payload type given at instantiation.
interface ptc_stream_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/ptc_front.sv
// Front part: temperature compensation and pressure numerator/divisor,
// pipelined over 9 stages. Depends on ptc_pkg.
module ptc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptc_pkg::calib_t    calib_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptc_pkg::in_item_t  in_data_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output ptc_pkg::job_t      job_o
);
  import ptc_pkg::*;

  logic [FrontStages-1:0] vld_q, vld_d;
  // stage registers
  logic [RawW-1:0] adcp_q [FrontStages-1];
  logic [31:0] temp_q [4:FrontStages-1];
  logic [31:0] a_q, b_q, tv1_q, tv1_dly_q, bb_q, tv2_q, tfine_q, tfine_dly_q;
  logic [63:0] v1_q, v1sq_q, v2a_q, v2b_q, w3_q, x_q, den_q, num_q;

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6;

  assign t1 = {16'd0, calib_i.temp[15:0]};
  assign t2 = {{16{calib_i.temp[31]}}, calib_i.temp[31:16]};
  assign t3 = {{16{calib_i.temp[47]}}, calib_i.temp[47:32]};
  assign p1 = {48'd0, calib_i.pa[15:0]};
  assign p2 = {{48{calib_i.pa[31]}}, calib_i.pa[31:16]};
  assign p3 = {{48{calib_i.pa[47]}}, calib_i.pa[47:32]};
  assign p4 = {{48{calib_i.pa[63]}}, calib_i.pa[63:48]};
  assign p5 = {{48{calib_i.pb[15]}}, calib_i.pb[15:0]};
  assign p6 = {{48{calib_i.pb[31]}}, calib_i.pb[31:16]};

  // Whole pipe moves together; a bubble in the last stage lets the rest advance.
  logic stall;
  assign stall = vld_q[FrontStages-1] && !job_ready_i;
  assign in_ready_o = !stall;
  assign vld_d = {vld_q[FrontStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (!stall) vld_q <= vld_d;
  end

  // Products are kept at 64 bits where the 64-bit path needs them;
  // the wide ones are split into two narrower stages where possible.
  logic [63:0] tf64;
  assign tf64 = {{32{tfine_dly_q[31]}}, tfine_dly_q};

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      adcp_q[0] <= in_data_i.raw_pressure;
      for (int i = 1; i < FrontStages - 1; i++) adcp_q[i] <= adcp_q[i-1];
      for (int i = 5; i < FrontStages; i++) temp_q[i] <= temp_q[i-1];
      // s0
      a_q <= {15'd0, in_data_i.raw_temperature[19:3]} - (t1 << 1);
      b_q <= {16'd0, in_data_i.raw_temperature[19:4]} - t1;
      // s1
      tv1_q <= 32'($signed(a_q * t2) >>> 11);
      bb_q <= 32'($signed(b_q * b_q) >>> 12);
      // s2
      tv1_dly_q <= tv1_q;
      tv2_q <= 32'($signed(bb_q * t3) >>> 14);
      // s3
      tfine_q <= tv1_dly_q + tv2_q;
      // s4
      tfine_dly_q <= tfine_q;
      temp_q[4] <= 32'($signed(tfine_q * 32'd5 + 32'd128) >>> 8);
      // s5: v1
      v1_q <= tf64 - 64'd128000;
      // s6: squares and linear terms; v1 always fits in 33 signed bits.
      v1sq_q <= $signed(v1_q[32:0]) * $signed(v1_q[32:0]);
      v2a_q <= (v1_q * p5) << 17;
      w3_q <= (v1_q * p2) << 12;
      // s7
      v2b_q <= v1sq_q * p6 + v2a_q + (p4 << 35);
      x_q <= 64'($signed(v1sq_q * p3) >>> 8) + w3_q;
      // s8
      den_q <= 64'($signed(((64'd1 << 47) + x_q) * p1) >>> 33);
      num_q <= (((64'd1048576 - {44'd0, adcp_q[FrontStages-2]}) << 31) - v2b_q)
               * 64'd3125;
    end
  end

  assign job_valid_o = vld_q[FrontStages-1];
  assign job_o.temp = temp_q[FrontStages-1];
  assign job_o.num = num_q;
  assign job_o.den = den_q;
endmodule

>>> design/ptc_queue.sv
// Short FIFO between front and back parts. Depends on ptc_pkg.
module ptc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ptc_pkg::job_t data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output ptc_pkg::job_t data_o
);
  import ptc_pkg::*;
  job_t mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QPtrW:0] cnt_q;

  assign full_o = (cnt_q == (QPtrW+1)'(QDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end
endmodule

>>> design/ptc_back.sv
// Back part: radix-2 signed divider and pressure post-processing.
// Depends on ptc_pkg.
module ptc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptc_pkg::calib_t    calib_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  ptc_pkg::job_t      job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptc_pkg::out_item_t out_o
);
  import ptc_pkg::*;

  back_state_e st_q, st_d;
  logic [6:0] cnt_q;
  logic [63:0] rem_q, quo_q, md_q, p_q, q_q, w1_q, w2_q, sqlo_q;
  logic [31:0] cross_q;
  logic neg_q, bad_q;
  logic [31:0] temp_q;
  logic [1:0] pst_q;
  out_item_t res_q;
  logic res_v_q;

  logic [63:0] p7, p8, p9;
  assign p7 = {{48{calib_i.pb[47]}}, calib_i.pb[47:32]};
  assign p8 = {{48{calib_i.pb[63]}}, calib_i.pb[63:48]};
  assign p9 = {{48{calib_i.pc[15]}}, calib_i.pc};

  logic [64:0] trial;
  assign trial = {rem_q, quo_q[63]} - {1'b0, md_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (job_valid_i) st_d = (job_i.den == '0) ? StOut : StDiv;
      StDiv: if (cnt_q == 7'(DivSteps - 1)) st_d = StPost;
      StPost: if (pst_q == 2'd3) st_d = StOut;
      StOut: if (!res_v_q || out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign job_ready_o = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      res_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StOut && (!res_v_q || out_ready_i)) res_v_q <= 1'b1;
      else if (out_ready_i) res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        temp_q <= job_i.temp;
        bad_q <= (job_i.den == '0);
        neg_q <= job_i.num[63] ^ job_i.den[63];
        quo_q <= job_i.num[63] ? -job_i.num : job_i.num;
        md_q <= job_i.den[63] ? -job_i.den : job_i.den;
        rem_q <= '0;
        cnt_q <= '0;
        pst_q <= '0;
        p_q <= '0;
      end
      StDiv: begin
        cnt_q <= cnt_q + 7'd1;
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= {rem_q[62:0], quo_q[63]};
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
      StPost: begin
        pst_q <= pst_q + 2'd1;
        if (pst_q == 2'd0) begin
          p_q <= neg_q ? -quo_q : quo_q;
          q_q <= 64'($signed(neg_q ? -quo_q : quo_q) >>> 13);
        end else if (pst_q == 2'd1) begin
          // The low 64 bits of q*q are built from 32-bit halves.
          sqlo_q <= q_q[31:0] * q_q[31:0];
          cross_q <= q_q[31:0] * q_q[63:32];
          w2_q <= 64'($signed(p8 * p_q) >>> 19);
        end else if (pst_q == 2'd2) begin
          w1_q <= sqlo_q + {cross_q[30:0], 1'b0, 32'd0};
        end else begin
          w1_q <= 64'($signed(p9 * w1_q) >>> 25);
        end
      end
      StOut: begin
        if (!res_v_q || out_ready_i) begin
          res_q.temperature_centi <= temp_q;
          res_q.pressure_invalid <= bad_q;
          res_q.pressure_q24_8 <= bad_q ? 32'd0 :
            32'((64'($signed(p_q + w1_q + w2_q) >>> 8)) + (p7 << 4));
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = res_v_q;
  assign out_o = res_q;
endmodule

>>> design/pressure_temperature_compensator.sv
// Channel     Dir  Payload
// in_if       in   raw_pressure, raw_temperature (20 bits each)
// out_if      out  temperature_centi, pressure_q24_8, pressure_invalid
// apb         in   four calibration registers, 64-bit data
// The front pipeline is 9 stages deep and takes one beat per cycle while
// fewer than four items sit between its input and the back part.
// The back part takes one job at a time: it runs 64 divider steps and four
// post-processing steps, then loads the output register; a zero divisor goes
// straight to the output register. So the back part sets the sustained rate.
// Reset clears all control state and the calibration registers.
// A 4-entry queue decouples front and back stalls.
`include "assert_macros.svh"
module pressure_temperature_compensator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ptc_stream_if.sink                 in_if,
  ptc_stream_if.source               out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptc_pkg::AddrW-1:0]  paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import ptc_pkg::*;
  calib_t calib_q;
  logic wr;
  logic [1:0] ridx;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign ridx = paddr[AddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) calib_q <= '0;
    else if (wr) begin
      unique case (reg_idx_e'(ridx))
        RegTemp: calib_q.temp <= pwdata[47:0];
        RegPressA: calib_q.pa <= pwdata;
        RegPressB: calib_q.pb <= pwdata;
        RegPressC: calib_q.pc <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(ridx))
      RegTemp: prdata = {16'd0, calib_q.temp};
      RegPressA: prdata = calib_q.pa;
      RegPressB: prdata = calib_q.pb;
      RegPressC: prdata = {48'd0, calib_q.pc};
      default: ;
    endcase
  end

  // Credit count keeps the front from overrunning the queue.
  logic [3:0] inflight_q;
  logic front_ok, f_ready, j_valid, q_full, q_valid, b_ready;
  job_t j_data, q_data;
  in_item_t in_data;
  out_item_t out_data;

  assign in_data = in_if.data;
  assign front_ok = (inflight_q < 4'd4);
  assign in_if.ready = f_ready && front_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= '0;
    else inflight_q <= inflight_q + 4'(in_if.valid && in_if.ready)
                       - 4'(q_valid && b_ready);
  end

  ptc_front u_front (
    .clk_i, .rst_ni, .calib_i(calib_q),
    .in_valid_i(in_if.valid && front_ok), .in_ready_o(f_ready),
    .in_data_i(in_data), .job_valid_o(j_valid), .job_ready_i(!q_full),
    .job_o(j_data)
  );

  ptc_queue u_queue (
    .clk_i, .rst_ni, .push_i(j_valid && !q_full), .full_o(q_full),
    .data_i(j_data), .pop_valid_o(q_valid), .pop_i(q_valid && b_ready),
    .data_o(q_data)
  );

  ptc_back u_back (
    .clk_i, .rst_ni, .calib_i(calib_q),
    .job_valid_i(q_valid), .job_ready_o(b_ready), .job_i(q_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_o(out_data)
  );
  assign out_if.data = out_data;

  `PTC_ASSERT(a_credit, clk_i, rst_ni, inflight_q <= 4'd4, "credit overflow")
  `PTC_ASSERT(a_nopushfull, clk_i, rst_ni, !(j_valid && q_full && inflight_q < 4'd4), "queue lost")
  `PTC_ASSERT_RST(a_rst, clk_i, !rst_ni |=> inflight_q == 4'd0 || rst_ni, "reset")
endmodule
